// ===== hdl/ebc_pkg.sv =====
// ----------------------------------------------------------------------------
// ebc_pkg
// Shared types, constants and helpers of the ECG beat classifier.
// ----------------------------------------------------------------------------
package ebc_pkg;

  localparam int unsigned ENERGY_WINDOW = 20;
  localparam int unsigned DC_TAPS       = 5;
  localparam int unsigned DIV_STEPS     = 9;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned DC_W     = 32;
  localparam int unsigned HP_W     = 24;
  localparam int unsigned E_W      = 53;
  localparam int unsigned THR_W    = 61;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_AW   = 1;
  localparam int unsigned BEAT_W   = 16;

  localparam int unsigned EQ_DEPTH = 4;
  localparam int unsigned EQ_AW    = 2;

  localparam logic [15:0] DC_COEF = 16'd65208;

  localparam logic [CFG_W-1:0] GAIN_RST  = 16'd524;
  localparam logic [CFG_W-1:0] DECAY_RST = 16'd64225;

  typedef enum logic [CFG_AW-1:0] {
    REG_THR_GAIN  = 1'b0,
    REG_THR_DECAY = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       is_qrs;
  } ebc_in_t;

  typedef struct packed {
    logic              beat_normal;
    logic [BEAT_W-1:0] beat_index;
  } ebc_out_t;

  typedef enum logic [3:0] {
    F_IDLE,
    F_MULDC,
    F_DC,
    F_MINMAX,
    F_DIVINIT,
    F_DIV,
    F_HP,
    F_SQ1,
    F_SQ2,
    F_ACC,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CMP,
    B_M1,
    B_M2,
    B_M3,
    B_M4,
    B_OUT
  } back_state_e;

  // radix-16 step of a divide by three: t < 48, returns {quotient digit, remainder}
  function automatic logic [5:0] div3_digit(input logic [5:0] t);
    logic [11:0] p;
    logic [3:0]  q;
    logic [5:0]  r;
    p = {6'b0, t} * 12'd43;
    q = p[10:7];
    r = t - ({2'b0, q} + {1'b0, q, 1'b0});
    return {q, r[1:0]};
  endfunction

endpackage

// ===== hdl/ebc_front.sv =====
// ----------------------------------------------------------------------------
// ebc_front
// Sample front end: dc blocker, median-type high pass, windowed energy.
// Pushes the energy of each flagged sample into the beat queue.
// ----------------------------------------------------------------------------
module ebc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ebc_pkg::ebc_in_t      word_i,
  output logic                  full_o,
  output logic                  eq_push_o,
  output logic [ebc_pkg::E_W-1:0] eq_data_o,
  input  logic                  eq_full_i
);
  import ebc_pkg::*;

  front_state_e state_q, state_d;

  logic signed [SAMPLE_W-1:0] x_q;
  logic                       qrs_q;
  logic signed [SAMPLE_W-1:0] prev_q;
  logic signed [DC_W-1:0]     dc_hist_q [DC_TAPS];
  logic [2:0]                 warm_q;
  logic signed [HP_W-1:0]     hp_win_q [ENERGY_WINDOW];
  logic [E_W-1:0]             energy_q;
  logic signed [57:0]         prod_q;
  logic signed [DC_W-1:0]     min_q, max_q;
  logic signed [34:0]         tot_q;
  logic [35:0]                mag_q;
  logic                       neg_q;
  logic [1:0]                 rem_q;
  logic [35:0]                quo_q;
  logic [3:0]                 cnt_q;
  logic signed [HP_W-1:0]     hp_q;
  logic [47:0]                sqnew_q;

  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;

  logic signed [17:0] diff;
  logic signed [57:0] rnd_full;
  logic signed [41:0] rnd;
  logic signed [42:0] dc_sum;
  logic signed [DC_W-1:0] dc_new;
  logic signed [DC_W-1:0] mn, mx;
  logic signed [34:0] tot;
  logic signed [34:0] mid_sum;
  logic [34:0]        mid_mag;
  logic [5:0]         dstep;
  logic signed [33:0] mid;
  logic signed [34:0] hp_full;
  logic signed [HP_W-1:0] hp_new;

  // dc blocker
  always_comb begin
    diff     = {{2{x_q[15]}}, x_q} - {{2{prev_q[15]}}, prev_q};
    rnd_full = prod_q + 58'sd32768;
    rnd      = rnd_full[57:16];
    dc_sum   = {rnd[41], rnd} + {{17{diff[17]}}, diff, 8'b0};
    if (warm_q == 3'd0) begin
      dc_new = '0;
    end else if (dc_sum[42:31] == '0 || dc_sum[42:31] == '1) begin
      dc_new = dc_sum[31:0];
    end else begin
      dc_new = dc_sum[42] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  // min, max and total of the five dc values
  always_comb begin
    mn  = dc_hist_q[0];
    mx  = dc_hist_q[0];
    tot = '0;
    for (int i = 0; i < DC_TAPS; i++) begin
      if (dc_hist_q[i] < mn) mn = dc_hist_q[i];
      if (dc_hist_q[i] > mx) mx = dc_hist_q[i];
      tot = tot + {{3{dc_hist_q[i][31]}}, dc_hist_q[i]};
    end
  end

  always_comb begin
    mid_sum = tot_q - {{3{min_q[31]}}, min_q} - {{3{max_q[31]}}, max_q};
    mid_mag = mid_sum[34] ? (~mid_sum + 35'sd1) : mid_sum;
    dstep   = div3_digit({rem_q, mag_q[35:32]});
    mid     = neg_q ? -$signed({1'b0, quo_q[32:0]}) : $signed({1'b0, quo_q[32:0]});
    hp_full = {{3{dc_hist_q[3][31]}}, dc_hist_q[3]} - {mid[33], mid};
    if (hp_full[34:23] == '0 || hp_full[34:23] == '1) begin
      hp_new = hp_full[23:0];
    end else begin
      hp_new = hp_full[34] ? 24'sh80_0000 : 24'sh7f_ffff;
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      F_MULDC: begin
        mul_a = {dc_hist_q[0][31], dc_hist_q[0]};
        mul_b = {9'b0, DC_COEF};
      end
      F_SQ1: begin
        mul_a = {{9{hp_q[23]}}, hp_q};
        mul_b = {hp_q[23], hp_q};
      end
      F_SQ2: begin
        mul_a = {{9{hp_win_q[ENERGY_WINDOW-1][23]}}, hp_win_q[ENERGY_WINDOW-1]};
        mul_b = {hp_win_q[ENERGY_WINDOW-1][23], hp_win_q[ENERGY_WINDOW-1]};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    full_o    = 1'b1;
    eq_push_o = 1'b0;
    eq_data_o = energy_q;
    case (state_q)
      F_IDLE: begin
        full_o = 1'b0;
        if (push_i) state_d = F_MULDC;
      end
      F_MULDC:   state_d = F_DC;
      F_DC:      state_d = (warm_q >= 3'd4) ? F_MINMAX : F_SQ1;
      F_MINMAX:  state_d = F_DIVINIT;
      F_DIVINIT: state_d = F_DIV;
      F_DIV: begin
        if (cnt_q == 4'(DIV_STEPS - 1)) state_d = F_HP;
      end
      F_HP:      state_d = F_SQ1;
      F_SQ1:     state_d = F_SQ2;
      F_SQ2:     state_d = F_ACC;
      F_ACC:     state_d = qrs_q ? F_PUSH : F_IDLE;
      F_PUSH: begin
        eq_push_o = !eq_full_i;
        if (!eq_full_i) state_d = F_IDLE;
      end
      default:   state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      warm_q   <= '0;
      energy_q <= '0;
      for (int i = 0; i < DC_TAPS; i++) dc_hist_q[i] <= '0;
      for (int i = 0; i < ENERGY_WINDOW; i++) hp_win_q[i] <= '0;
    end else begin
      case (state_q)
        F_DC: begin
          for (int i = DC_TAPS - 1; i > 0; i--) dc_hist_q[i] <= dc_hist_q[i-1];
          dc_hist_q[0] <= dc_new;
          prev_q       <= x_q;
          if (warm_q < 3'(DC_TAPS)) warm_q <= warm_q + 3'd1;
        end
        F_ACC: begin
          for (int i = ENERGY_WINDOW - 1; i > 0; i--) hp_win_q[i] <= hp_win_q[i-1];
          hp_win_q[0] <= hp_q;
          energy_q    <= energy_q + {5'b0, sqnew_q} - {5'b0, prod_q[47:0]};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      F_IDLE: begin
        x_q   <= word_i.sample;
        qrs_q <= word_i.is_qrs;
      end
      F_DC: hp_q <= '0;
      F_MINMAX: begin
        min_q <= mn;
        max_q <= mx;
        tot_q <= tot;
      end
      F_DIVINIT: begin
        mag_q <= {1'b0, mid_mag};
        neg_q <= mid_sum[34];
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= '0;
      end
      F_DIV: begin
        mag_q <= {mag_q[31:0], 4'b0};
        quo_q <= {quo_q[31:0], dstep[5:2]};
        rem_q <= dstep[1:0];
        cnt_q <= cnt_q + 4'd1;
      end
      F_HP:  hp_q    <= hp_new;
      F_SQ2: sqnew_q <= prod_q[47:0];
      default: ;
    endcase
  end

endmodule

// ===== hdl/ebc_fifo.sv =====
// ----------------------------------------------------------------------------
// ebc_fifo
// Short queue of beat energies between the front end and the classifier.
// ----------------------------------------------------------------------------
module ebc_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic [ebc_pkg::E_W-1:0] data_i,
  output logic                    full_o,
  input  logic                    pop_i,
  output logic [ebc_pkg::E_W-1:0] data_o,
  output logic                    empty_o
);
  import ebc_pkg::*;

  logic [E_W-1:0]   mem_q [EQ_DEPTH];
  logic [EQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [EQ_AW:0]   cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (EQ_AW+1)'(EQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

// ===== hdl/ebc_back.sv =====
// ----------------------------------------------------------------------------
// ebc_back
// Beat classifier: threshold compare and update, beat numbering, result word.
// ----------------------------------------------------------------------------
module ebc_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ebc_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [ebc_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                       eq_empty_i,
  input  logic [ebc_pkg::E_W-1:0]    eq_data_i,
  output logic                       eq_pop_o,
  output ebc_pkg::ebc_out_t          word_o,
  output logic                       empty_o,
  input  logic                       pop_i
);
  import ebc_pkg::*;

  back_state_e state_q, state_d;

  logic [CFG_W-1:0]  gain_q, decay_q;
  logic [THR_W-1:0]  thr_q;
  logic [BEAT_W-1:0] beat_q;
  logic [E_W-1:0]    e_q;
  logic              normal_q;
  logic [47:0]       prod_q;
  logic [61:0]       acc_q;
  ebc_out_t          out_q;
  logic              out_valid_q;

  logic [31:0]      mul_a;
  logic [CFG_W-1:0] mul_b;
  logic             out_load;

  assign word_o  = out_q;
  assign empty_o = !out_valid_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      B_CMP: begin
        mul_a = e_q[31:0];
        mul_b = gain_q;
      end
      B_M1: begin
        mul_a = {11'b0, e_q[E_W-1:32]};
        mul_b = gain_q;
      end
      B_M2: begin
        mul_a = thr_q[31:0];
        mul_b = decay_q;
      end
      B_M3: begin
        mul_a = {3'b0, thr_q[THR_W-1:32]};
        mul_b = decay_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    eq_pop_o = 1'b0;
    out_load = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!eq_empty_i) begin
          eq_pop_o = 1'b1;
          state_d  = B_CMP;
        end
      end
      B_CMP: state_d = B_M1;
      B_M1:  state_d = B_M2;
      B_M2:  state_d = B_M3;
      B_M3:  state_d = B_M4;
      B_M4:  state_d = B_OUT;
      B_OUT: begin
        if (!out_valid_q || pop_i) begin
          out_load = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= GAIN_RST;
      decay_q     <= DECAY_RST;
      thr_q       <= '0;
      beat_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_addr_i))
          REG_THR_GAIN:  gain_q  <= cfg_data_i;
          REG_THR_DECAY: decay_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        beat_q      <= beat_q + 1'b1;
        if (normal_q) thr_q <= acc_q[61] ? '1 : acc_q[THR_W-1:0];
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      B_IDLE: e_q <= eq_data_i;
      B_CMP:  normal_q <= ({e_q, 8'b0} >= thr_q);
      B_M1:   acc_q <= {22'b0, prod_q[47:8]};
      B_M2:   acc_q <= acc_q + ({14'b0, prod_q} << 24);
      B_M3:   acc_q <= acc_q + {30'b0, prod_q[47:16]};
      B_M4:   acc_q <= acc_q + ({14'b0, prod_q} << 16);
      default: ;
    endcase
    if (out_load) begin
      out_q.beat_normal <= normal_q;
      out_q.beat_index  <= beat_q;
    end
  end

endmodule

// ===== hdl/ecg_beat_classifier.sv =====
// ----------------------------------------------------------------------------
// ecg_beat_classifier
// Energy-threshold classifier of ECG beats, top level.
// ----------------------------------------------------------------------------
// Input words (sample, is_qrs) go in through push/full: a word is taken at a
// clock edge with push high and full low. Every sample runs through the dc
// blocker, the five-tap median-type high pass (skipped for the first four
// samples) and the energy window; a flagged sample produces one result word,
// others produce none. Result words (beat_normal, beat_index) come out through
// empty/pop: the oldest word stands on word_o while empty is low and leaves on
// pop. The front end takes one sample at a time and holds full high until it
// is through with it, stepped by its sequencer through the shared multiplier
// and the nine-step radix-16 divide by three of the median sum; the first four
// samples skip the high pass, and a flagged sample ends with a push into the
// queue. The classifier works on one beat at a time on its own multiplier.
// A four-deep energy queue sits between the two halves, so a stalled result
// reader first fills the result register and the classifier, then the queue,
// and only then holds the front end in its push step with full high.
// Reset clears all history, energy, threshold and beat count and loads the
// default gain and decay; no startup sweep is needed.
// Registers (cfg_addr_i): 0 threshold gain, 1 threshold decay, both Q0.16.
// ----------------------------------------------------------------------------
module ecg_beat_classifier (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  input  ebc_pkg::ebc_in_t           word_i,
  output logic                       full,
  output logic                       empty,
  input  logic                       pop,
  output ebc_pkg::ebc_out_t          word_o,
  input  logic                       cfg_we_i,
  input  logic [ebc_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [ebc_pkg::CFG_W-1:0]  cfg_data_i
);
  import ebc_pkg::*;

  logic           eq_push, eq_full, eq_pop, eq_empty;
  logic [E_W-1:0] eq_wdata, eq_rdata;

  ebc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .word_i    (word_i),
    .full_o    (full),
    .eq_push_o (eq_push),
    .eq_data_o (eq_wdata),
    .eq_full_i (eq_full)
  );

  ebc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (eq_push),
    .data_i  (eq_wdata),
    .full_o  (eq_full),
    .pop_i   (eq_pop),
    .data_o  (eq_rdata),
    .empty_o (eq_empty)
  );

  ebc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .eq_empty_i (eq_empty),
    .eq_data_i  (eq_rdata),
    .eq_pop_o   (eq_pop),
    .word_o     (word_o),
    .empty_o    (empty),
    .pop_i      (pop)
  );

endmodule
